### design/sgpw_pkg.sv
// shared types and constants of the scaled glyph pixel writer
// no dependencies
package sgpw_pkg;

   localparam int GLYPH_SIZE   = 8;
   localparam int GLYPH_COL_W  = 3;
   localparam int SCALE_W      = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;
   localparam int QUEUE_CNT_W  = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_PITCH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_COLOR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_COLOR  = 3'd4;

   // pixel formats
   localparam logic [1:0] FMT_GRAY8  = 2'd0;
   localparam logic [1:0] FMT_RGB565 = 2'd1;
   localparam logic [1:0] FMT_RGB24  = 2'd2;
   localparam logic [1:0] FMT_RGB32  = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [7:0] glyph_bits;
      logic [9:0] char_column;
      logic [9:0] char_row;
      logic [4:0] line_in_cell;
      logic       invert;
   } req_type;

   typedef struct packed {
      logic [31:0] byte_address;
      logic [31:0] pixel_word;
      logic [2:0]  byte_count;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  pixel_format;
      logic [2:0]  scale;
      logic [15:0] line_pitch;
      logic [23:0] dark_color;
      logic [23:0] light_color;
   } cfg_type;

   // one cell line ready for drawing
   typedef struct packed {
      logic [31:0]        base_address;
      logic [31:0]        fg_word;
      logic [31:0]        bg_word;
      logic [2:0]         byte_count;
      logic [7:0]         glyph_bits;
      logic [SCALE_W-1:0] scale_m1;
   } job_type;

endpackage

### design/sgpw_front.sv
// front end: accepts a font row, resolves colors and the line base address
// depends on sgpw_pkg
module sgpw_front
   import sgpw_pkg::*;
#(
   parameter int MAX_SCALE = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   input  cfg_type                cfg,
   input  logic [QUEUE_CNT_W-1:0] queue_level,
   output logic                   push,
   output job_type                push_data
);

   function automatic logic [31:0] format_color(input logic [23:0] color,
                                                input logic [1:0]  fmt);
      logic [31:0] word;
      unique case (fmt)
         FMT_GRAY8:  word = {24'd0, color[7:0]};
         FMT_RGB565: word = {16'd0, color[23:19], color[15:10], color[7:3]};
         FMT_RGB24:  word = {8'd0, color};
         FMT_RGB32:  word = {ALPHA_OPAQUE, color};
         default:    word = {8'd0, color};
      endcase
      return word;
   endfunction

   function automatic logic [2:0] format_bytes(input logic [1:0] fmt);
      logic [2:0] n;
      unique case (fmt)
         FMT_GRAY8:  n = 3'd1;
         FMT_RGB565: n = 3'd2;
         FMT_RGB24:  n = 3'd3;
         FMT_RGB32:  n = 3'd4;
         default:    n = 3'd4;
      endcase
      return n;
   endfunction

   logic accept;
   logic [SCALE_W-1:0] eff_scale;
   logic [23:0] fg_color, bg_color;

   // stage a
   logic        va_ff, va_in;
   req_type     req_a_ff;
   logic [SCALE_W-1:0] scale_a_ff;
   logic [31:0] fg_a_ff, bg_a_ff;
   logic [2:0]  bytes_a_ff;

   // stage b
   logic        vb_ff, vb_in;
   logic [15:0] y_b_ff, x_b_ff;
   logic [5:0]  cell_a;
   logic [31:0] fg_b_ff, bg_b_ff;
   logic [2:0]  bytes_b_ff;
   logic [7:0]  bits_b_ff;
   logic [SCALE_W-1:0] scale_b_ff;

   // stage c
   logic        vc_ff, vc_in;
   logic [31:0] yp_c_ff;
   logic [17:0] xb_c_ff;
   logic [31:0] fg_c_ff, bg_c_ff;
   logic [2:0]  bytes_c_ff;
   logic [7:0]  bits_c_ff;
   logic [SCALE_W-1:0] scale_c_ff;

   logic [QUEUE_CNT_W:0] pending;

   // items in flight plus queued ones never exceed the queue depth
   assign pending = {1'b0, queue_level} + (QUEUE_CNT_W+1)'(va_ff)
                    + (QUEUE_CNT_W+1)'(vb_ff) + (QUEUE_CNT_W+1)'(vc_ff);
   assign busy    = pending >= (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
   assign accept  = start && !busy;

   always_comb begin
      if (cfg.scale == 3'd0) begin
         eff_scale = 3'd1;
      end else if ({1'b0, cfg.scale} > 4'(MAX_SCALE)) begin
         eff_scale = 3'(MAX_SCALE);
      end else begin
         eff_scale = cfg.scale;
      end
      fg_color = req_data.invert ? cfg.light_color : cfg.dark_color;
      bg_color = req_data.invert ? cfg.dark_color  : cfg.light_color;
   end

   assign va_in  = accept;
   assign vb_in  = va_ff;
   assign vc_in  = vb_ff;
   assign cell_a = {scale_a_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_a_ff   <= req_data;
         scale_a_ff <= eff_scale;
         fg_a_ff    <= format_color(fg_color, cfg.pixel_format);
         bg_a_ff    <= format_color(bg_color, cfg.pixel_format);
         bytes_a_ff <= format_bytes(cfg.pixel_format);
      end
      // cell origin in pixels
      y_b_ff     <= 16'(req_a_ff.char_row * cell_a) + 16'(req_a_ff.line_in_cell);
      x_b_ff     <= 16'(req_a_ff.char_column * cell_a);
      fg_b_ff    <= fg_a_ff;
      bg_b_ff    <= bg_a_ff;
      bytes_b_ff <= bytes_a_ff;
      bits_b_ff  <= req_a_ff.glyph_bits;
      scale_b_ff <= scale_a_ff;
      // pixel origin to bytes
      yp_c_ff    <= y_b_ff * cfg.line_pitch;
      xb_c_ff    <= 18'(x_b_ff * bytes_b_ff);
      fg_c_ff    <= fg_b_ff;
      bg_c_ff    <= bg_b_ff;
      bytes_c_ff <= bytes_b_ff;
      bits_c_ff  <= bits_b_ff;
      scale_c_ff <= scale_b_ff;
   end

   assign push                   = vc_ff;
   assign push_data.base_address = yp_c_ff + {14'd0, xb_c_ff};
   assign push_data.fg_word      = fg_c_ff;
   assign push_data.bg_word      = bg_c_ff;
   assign push_data.byte_count   = bytes_c_ff;
   assign push_data.glyph_bits   = bits_c_ff;
   assign push_data.scale_m1     = scale_c_ff - SCALE_W'(1);

endmodule

### design/sgpw_queue.sv
// short job queue between front end and pixel sequencer
// depends on sgpw_pkg
module sgpw_queue
   import sgpw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  job_type                push_data,
   input  logic                   pop,
   output job_type                head,
   output logic                   empty,
   output logic [QUEUE_CNT_W-1:0] level
);

   job_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign level = count_ff;

endmodule

### design/sgpw_back.sv
// pixel sequencer: expands one job into 8*scale framebuffer writes
// depends on sgpw_pkg
module sgpw_back
   import sgpw_pkg::*;
#(
   parameter int MAX_SCALE = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  job_type head,
   input  logic    empty,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int SUB_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

   logic                   active_ff, active_in;
   job_type                job_ff;
   logic [SUB_W-1:0]       sub_ff, sub_in;
   logic [GLYPH_COL_W-1:0] col_ff, col_in;
   logic [31:0]            addr_ff, addr_in;
   logic                   sub_end, last_now;
   logic                   valid_ff;
   rsp_type                rsp_ff, rsp_in;

   assign sub_end  = sub_ff == job_ff.scale_m1[SUB_W-1:0];
   assign last_now = sub_end && (col_ff == GLYPH_COL_W'(GLYPH_SIZE - 1));
   assign pop      = !empty && (!active_ff || last_now);

   always_comb begin
      active_in = active_ff;
      sub_in    = sub_ff;
      col_in    = col_ff;
      addr_in   = addr_ff + {29'd0, job_ff.byte_count};
      if (pop) begin
         active_in = 1'b1;
         sub_in    = '0;
         col_in    = '0;
         addr_in   = head.base_address;
      end else if (active_ff) begin
         if (last_now) begin
            active_in = 1'b0;
         end
         if (sub_end) begin
            sub_in = '0;
            col_in = col_ff + GLYPH_COL_W'(1);
         end else begin
            sub_in = sub_ff + SUB_W'(1);
         end
      end
      rsp_in.byte_address = addr_ff;
      rsp_in.pixel_word   = job_ff.glyph_bits[col_ff] ? job_ff.fg_word : job_ff.bg_word;
      rsp_in.byte_count   = job_ff.byte_count;
      rsp_in.last_pixel   = last_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         sub_ff    <= '0;
         col_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= active_ff;
         sub_ff    <= sub_in;
         col_ff    <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
      if (pop) begin
         job_ff <= head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/scaled_glyph_pixel_writer.sv
// top level of the scaled glyph pixel writer: csr bank, front end, queue, sequencer
// depends on sgpw_pkg, sgpw_front, sgpw_queue, sgpw_back
// rows pass front stages a, b, c, the queue, the sequencer and its output register
// throughput: one pixel transfer per cycle while a row is being written, set by the
// pixel sequencer; rows follow each other with no gap while the queue holds work
// reset: synchronous, clears all control state and loads the csr reset values
// the receiver cannot stall: every strobed pixel is taken at the end of its cycle
module scaled_glyph_pixel_writer
   import sgpw_pkg::*;
#(
   parameter int MAX_SCALE = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // csr bank
   logic [1:0]  pixel_format_ff;
   logic [2:0]  scale_ff;
   logic [15:0] line_pitch_ff;
   logic [23:0] dark_color_ff;
   logic [23:0] light_color_ff;
   cfg_type     cfg;

   // front to queue to sequencer
   logic                   push, pop, empty;
   job_type                push_data, head;
   logic [QUEUE_CNT_W-1:0] queue_level;

   // register writes, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_GRAY8;
         scale_ff        <= 3'd1;
         line_pitch_ff   <= 16'd2048;
         dark_color_ff   <= 24'h000000;
         light_color_ff  <= 24'hFFFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[1:0];
            CSR_SCALE:        scale_ff        <= csr_wdata[2:0];
            CSR_LINE_PITCH:   line_pitch_ff   <= csr_wdata[15:0];
            CSR_DARK_COLOR:   dark_color_ff   <= csr_wdata;
            CSR_LIGHT_COLOR:  light_color_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.pixel_format = pixel_format_ff;
   assign cfg.scale        = scale_ff;
   assign cfg.line_pitch   = line_pitch_ff;
   assign cfg.dark_color   = dark_color_ff;
   assign cfg.light_color  = light_color_ff;

   // front end: three stages, color formatting then address multiplies
   sgpw_front #(
      .MAX_SCALE(MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .cfg        (cfg),
      .queue_level(queue_level),
      .push       (push),
      .push_data  (push_data)
   );

   // job queue, front stops accepting once in-flight plus queued work fills it
   sgpw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .level    (queue_level)
   );

   // pixel sequencer, one transfer per cycle while it holds a job
   sgpw_back #(
      .MAX_SCALE(MAX_SCALE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // queue never overfills thanks to the credit count on busy
   assert property (@(posedge clock) disable iff (reset)
      queue_level <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("job queue overfilled");

   // no pop from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty job queue");

   // a cell line is written without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_pixel |=> rsp_valid)
      else $error("gap inside a cell line");

   // neighboring pixels of one line are one pixel apart in bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_pixel |=>
         rsp_data.byte_address == $past(rsp_data.byte_address)
                                  + {29'd0, $past(rsp_data.byte_count)})
      else $error("pixel address step mismatch");

endmodule

### dv/testbench.sv
// self-checking testbench for scaled_glyph_pixel_writer: font rows in, pixel writes out
// depends on sgpw_pkg and the scaled_glyph_pixel_writer rtl
// each row is expanded into its expected pixel writes, which are checked in order
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sgpw_pkg::*;

   localparam int MAX_SCALE       = 4;
   localparam int IDLE_LIMIT      = 1000;  // cycles with no transfer before giving up
   localparam int TAIL_CYCLES     = 40;    // well past the first pixel write of the last accepted row
   localparam int RANDOM_PHASES   = 10;
   localparam int ROWS_PER_PHASE  = 30;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // shadow of the register bank, updated as each write lands
   cfg_type csr_shadow;
   // pixel writes still owed by the block, oldest first
   rsp_type pending_pixels[$];
   int      error_count = 0;
   int      idle_cycles = 0;

   scaled_glyph_pixel_writer #(
      .MAX_SCALE(MAX_SCALE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // pixel prediction
   // ---------------------------------------------------------------

   // zero scale behaves as one, anything past the maximum saturates
   function automatic int effective_scale(input cfg_type cfg);
      int s;
      s = cfg.scale;
      if (s == 0) s = 1;
      if (s > MAX_SCALE) s = MAX_SCALE;
      return s;
   endfunction

   // palette color (r,g,b bytes, blue lowest) packed for the framebuffer format
   function automatic logic [31:0] format_pixel(input logic [1:0] fmt,
                                                input logic [23:0] color,
                                                output logic [2:0] nbytes);
      logic [7:0] r, g, b;
      r = color[23:16];
      g = color[15:8];
      b = color[7:0];
      case (fmt)
         FMT_GRAY8: begin
            nbytes = 3'd1;
            return {24'd0, b};
         end
         FMT_RGB565: begin
            nbytes = 3'd2;
            return {16'd0, r[7:3], g[7:2], b[7:3]};
         end
         FMT_RGB24: begin
            nbytes = 3'd3;
            return {8'd0, r, g, b};
         end
         default: begin
            nbytes = 3'd4;
            return {ALPHA_OPAQUE, r, g, b};
         end
      endcase
   endfunction

   // expand one font row into its 8*scale pixel writes, left to right
   task automatic predict_pixel_writes(input req_type row);
      int          s;
      int          cell_px;
      logic [2:0]  nbytes;
      logic [31:0] fg_word, bg_word, x, y;
      rsp_type     pix;
      s       = effective_scale(csr_shadow);
      cell_px = GLYPH_SIZE * s;
      fg_word = format_pixel(csr_shadow.pixel_format,
                             row.invert ? csr_shadow.light_color : csr_shadow.dark_color,
                             nbytes);
      bg_word = format_pixel(csr_shadow.pixel_format,
                             row.invert ? csr_shadow.dark_color : csr_shadow.light_color,
                             nbytes);
      // line_in_cell is a plain y offset, even past the cell height
      y = 32'(row.char_row) * 32'(cell_px) + 32'(row.line_in_cell);
      for (int k = 0; k < cell_px; k++) begin
         x = 32'(row.char_column) * 32'(cell_px) + 32'(k);
         // address arithmetic wraps at 32 bits by construction
         pix.byte_address = x * 32'(nbytes) + y * 32'(csr_shadow.line_pitch);
         pix.pixel_word   = row.glyph_bits[(k / s) % GLYPH_SIZE] ? fg_word : bg_word;
         pix.byte_count   = nbytes;
         pix.last_pixel   = (k == cell_px - 1);
         pending_pixels.push_back(pix);
      end
   endtask

   // ---------------------------------------------------------------
   // drivers: inputs change on the falling edge
   // ---------------------------------------------------------------

   // one row transfer; start is left high so back-to-back rows need no gap
   task automatic send_glyph_row(input req_type row, input int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= row;
      do @(posedge clock); while (busy);
      predict_pixel_writes(row);
   endtask

   // drop start and hold off until every owed pixel has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // single register write; out-of-range indexes and excess bits are dropped
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_PIXEL_FORMAT: csr_shadow.pixel_format = value[1:0];
         CSR_SCALE:        csr_shadow.scale        = value[2:0];
         CSR_LINE_PITCH:   csr_shadow.line_pitch   = value[15:0];
         CSR_DARK_COLOR:   csr_shadow.dark_color   = value[23:0];
         CSR_LIGHT_COLOR:  csr_shadow.light_color  = value[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly lines inside the cell, a quarter anywhere in the 5-bit range
   function automatic req_type random_glyph_row();
      req_type row;
      int      cell_px;
      cell_px          = GLYPH_SIZE * effective_scale(csr_shadow);
      row.glyph_bits   = 8'($urandom);
      row.char_column  = 10'($urandom);
      row.char_row     = 10'($urandom);
      row.line_in_cell = ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                      : 5'($urandom_range(0, cell_px - 1));
      row.invert       = 1'($urandom);
      return row;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset register values: gray8, scale 1, pitch 2048, black on white
   task automatic test_reset_defaults();
      send_glyph_row('{8'h00, 10'd0,    10'd0,    5'd0,  1'b0}, 0);
      send_glyph_row('{8'hFF, 10'd1023, 10'd1023, 5'd31, 1'b1}, 0);
      send_glyph_row('{8'h01, 10'd1,    10'd2,    5'd3,  1'b0}, 0);
      send_glyph_row('{8'h80, 10'd1023, 10'd0,    5'd7,  1'b1}, 0);
      // line past the bottom of an 8 line cell
      send_glyph_row('{8'hA5, 10'd512,  10'd341,  5'd8,  1'b0}, 0);
   endtask

   // every pixel format with colors whose bytes all differ
   task automatic test_pixel_formats();
      logic [1:0] formats[4];
      formats = '{FMT_GRAY8, FMT_RGB565, FMT_RGB24, FMT_RGB32};
      wait_drained();
      write_csr(CSR_DARK_COLOR, 24'h13579B);
      write_csr(CSR_LIGHT_COLOR, 24'hECA864);
      foreach (formats[i]) begin
         wait_drained();
         // junk in the upper data bits must not leak into the format
         write_csr(CSR_PIXEL_FORMAT, {22'h2AAAAA, formats[i]});
         send_glyph_row('{8'h5A, 10'(37 * i), 10'(11 * i), 5'(i), 1'(i)}, 0);
         send_glyph_row('{8'hC3, 10'd1023, 10'd1023, 5'd7, 1'(~i)}, 0);
      end
   endtask

   // zero and oversized scales, pitch extremes, unused register indexes
   task automatic test_scale_and_pitch();
      int scales[6];
      scales = '{0, 2, 3, 4, 5, 7};
      foreach (scales[i]) begin
         wait_drained();
         write_csr(CSR_SCALE, {21'h1FFFFF, 3'(scales[i])});
         send_glyph_row('{8'h96, 10'd1023, 10'd1023, 5'd31, 1'(i)}, 0);
      end
      wait_drained();
      // upper byte dropped, pitch becomes zero
      write_csr(CSR_LINE_PITCH, 24'hFF0000);
      write_csr(CSR_DARK_COLOR, 24'h000000);
      write_csr(CSR_LIGHT_COLOR, 24'hFFFFFF);
      send_glyph_row('{8'h3C, 10'd1023, 10'd1023, 5'd31, 1'b0}, 0);
      wait_drained();
      write_csr(CSR_LINE_PITCH, 24'h00FFFF);
      // writes past the last register change nothing
      for (int idx = CSR_LIGHT_COLOR + 1; idx < 2 ** CSR_INDEX_W; idx++)
         write_csr(CSR_INDEX_W'(idx), 24'hFFFFFF);
      send_glyph_row('{8'hFF, 10'd1023, 10'd1023, 5'd31, 1'b1}, 3);
      send_glyph_row('{8'h00, 10'd0,    10'd1023, 5'd0,  1'b1}, 0);
   endtask

   // random register settings, each followed by a run of random rows
   task automatic test_random_traffic();
      bit bursty;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         write_csr(CSR_PIXEL_FORMAT, 24'($urandom));
         write_csr(CSR_SCALE,        24'($urandom));
         write_csr(CSR_LINE_PITCH,   24'($urandom));
         write_csr(CSR_DARK_COLOR,   24'($urandom));
         write_csr(CSR_LIGHT_COLOR,  24'($urandom));
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_INDEX_W'($urandom_range(CSR_LIGHT_COLOR + 1, 2 ** CSR_INDEX_W - 1)),
                      24'($urandom));
         // some phases stream with no gaps at all, the rest idle at random
         bursty = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < ROWS_PER_PHASE; n++) begin
            // let the pipeline run completely dry mid-phase now and then
            if (n == ROWS_PER_PHASE / 2 && p % 3 == 0)
               wait_drained();
            send_glyph_row(random_glyph_row(), bursty ? 0 : $urandom_range(0, 15));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // result checking: outputs sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : pixel_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel write at address %h", rsp_data.byte_address);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.byte_address !== want.byte_address) begin
               $error("byte_address: expected %h, actual %h",
                      want.byte_address, rsp_data.byte_address);
               error_count++;
            end
            if (rsp_data.pixel_word !== want.pixel_word) begin
               $error("pixel_word: expected %h, actual %h",
                      want.pixel_word, rsp_data.pixel_word);
               error_count++;
            end
            if (rsp_data.byte_count !== want.byte_count) begin
               $error("byte_count: expected %0d, actual %0d",
                      want.byte_count, rsp_data.byte_count);
               error_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %b, actual %b",
                      want.last_pixel, rsp_data.last_pixel);
               error_count++;
            end
         end
      end
   end

   // watchdog: any row or pixel transfer restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[scaled_glyph_pixel_writer] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      csr_shadow.pixel_format = FMT_GRAY8;
      csr_shadow.scale        = 3'd1;
      csr_shadow.line_pitch   = 16'd2048;
      csr_shadow.dark_color   = 24'h000000;
      csr_shadow.light_color  = 24'hFFFFFF;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_pixel_formats();
      test_scale_and_pitch();
      test_random_traffic();

      // everything owed has arrived; linger to catch stray writes
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[scaled_glyph_pixel_writer] OK");
      else
         $display("[scaled_glyph_pixel_writer] ERROR");
      $finish;
   end

endmodule
